// File: sv/mkse_pkg.sv
package mkse_pkg;

	localparam int unsigned LenW    = 24;
	localparam int unsigned GroupW  = 4;
	localparam int unsigned SymW    = 8;
	localparam int unsigned ElemMax = 6;
	localparam int unsigned CountW  = 3;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CFG_DOT       = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DASH      = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_ELEM_GAP  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_CHAR_GAP  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_WORD_GAP  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_GROUP     = 3'd5;

	localparam logic [LenW-1:0]   DOT_RST       = 24'd2000;
	localparam logic [LenW-1:0]   DASH_RST      = 24'd6000;
	localparam logic [LenW-1:0]   ELEM_GAP_RST  = 24'd2000;
	localparam logic [LenW-1:0]   CHAR_GAP_RST  = 24'd6000;
	localparam logic [LenW-1:0]   WORD_GAP_RST  = 24'd14000;
	localparam logic [GroupW-1:0] GROUP_RST     = 4'd5;

	// segment currently presented on the output
	typedef enum logic [1:0] {
		SEG_TONE,
		SEG_GAP,
		SEG_TRAIL,
		SEG_BAD
	} seg_kind_t;

	typedef struct packed {
		logic load;     // take the looked-up character
		logic advance;  // step to the next element
		logic close;    // trailing gap delivered, update group position
	} dp_cmd_t;

	typedef struct packed {
		logic bad;      // loaded character has no code
		logic more;     // further elements follow the current one
	} dp_stat_t;

	typedef struct packed {
		logic              hit;
		logic [CountW-1:0] count;
		logic [ElemMax-1:0] bits;  // first element in highest used bit, 1 = dash
	} rom_entry_t;

	function automatic rom_entry_t mk(input logic [CountW-1:0] count,
	                                  input logic [ElemMax-1:0] bits);
		rom_entry_t e;
		e.hit   = 1'b1;
		e.count = count;
		e.bits  = bits;
		return e;
	endfunction

	function automatic rom_entry_t morse_lookup(input logic [SymW-1:0] sym);
		rom_entry_t e;
		e = '0;
		case (sym)
			"0": e = mk(3'd5, 6'd31);
			"1": e = mk(3'd5, 6'd15);
			"2": e = mk(3'd5, 6'd7);
			"3": e = mk(3'd5, 6'd3);
			"4": e = mk(3'd5, 6'd1);
			"5": e = mk(3'd5, 6'd0);
			"6": e = mk(3'd5, 6'd16);
			"7": e = mk(3'd5, 6'd24);
			"8": e = mk(3'd5, 6'd28);
			"9": e = mk(3'd5, 6'd30);
			"A": e = mk(3'd2, 6'd1);
			"B": e = mk(3'd4, 6'd8);
			"C": e = mk(3'd4, 6'd10);
			"D": e = mk(3'd3, 6'd4);
			"E": e = mk(3'd1, 6'd0);
			"F": e = mk(3'd4, 6'd2);
			"G": e = mk(3'd3, 6'd6);
			"H": e = mk(3'd4, 6'd0);
			"I": e = mk(3'd2, 6'd0);
			"J": e = mk(3'd4, 6'd7);
			"K": e = mk(3'd3, 6'd5);
			"L": e = mk(3'd4, 6'd4);
			"M": e = mk(3'd2, 6'd3);
			"N": e = mk(3'd2, 6'd2);
			"O": e = mk(3'd3, 6'd7);
			"P": e = mk(3'd4, 6'd6);
			"Q": e = mk(3'd4, 6'd13);
			"R": e = mk(3'd3, 6'd2);
			"S": e = mk(3'd3, 6'd0);
			"T": e = mk(3'd1, 6'd1);
			"U": e = mk(3'd3, 6'd1);
			"V": e = mk(3'd4, 6'd1);
			"W": e = mk(3'd3, 6'd3);
			"X": e = mk(3'd4, 6'd9);
			"Y": e = mk(3'd4, 6'd11);
			"Z": e = mk(3'd4, 6'd12);
			"?": e = mk(3'd6, 6'd12);
			",": e = mk(3'd6, 6'd51);
			"!": e = mk(3'd6, 6'd49);
			".": e = mk(3'd6, 6'd21);
			";": e = mk(3'd6, 6'd42);
			"/": e = mk(3'd5, 6'd18);
			"=": e = mk(3'd5, 6'd17);
			"-": e = mk(3'd6, 6'd33);
			8'h09: e = mk(3'd6, 6'd30);  // tab carries the apostrophe pattern
			"(": e = mk(3'd5, 6'd22);
			")": e = mk(3'd6, 6'd45);
			8'h22: e = mk(3'd6, 6'd18);  // double quote
			":": e = mk(3'd6, 6'd56);
			"_": e = mk(3'd6, 6'd13);
			"@": e = mk(3'd6, 6'd26);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

// File: sv/mkse_dp.sv
module mkse_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mkse_pkg::CfgIdxW-1:0]    cfg_addr,
	input  logic [mkse_pkg::LenW-1:0]       cfg_wdata,
	input  logic [mkse_pkg::SymW-1:0]       symbol,
	input  mkse_pkg::dp_cmd_t               cmd,
	input  mkse_pkg::seg_kind_t             kind,
	output mkse_pkg::dp_stat_t              stat,
	output logic                            tone_on,
	output logic [mkse_pkg::LenW-1:0]       segment_length,
	output logic                            bad_symbol,
	output logic                            last
);
	import mkse_pkg::*;

	logic [LenW-1:0]    dot_q, dash_q, elem_gap_q, char_gap_q, word_gap_q;
	logic [GroupW-1:0]  group_size_q;
	logic [GroupW-1:0]  group_pos_q;
	logic [ElemMax-1:0] elem_q;
	logic [CountW-1:0]  rem_q;
	logic               bad_q;
	rom_entry_t         entry;
	logic               word_end;

	assign entry    = morse_lookup(symbol);
	assign word_end = ({1'b0, group_pos_q} + 5'd1) >= {1'b0, group_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q        <= DOT_RST;
			dash_q       <= DASH_RST;
			elem_gap_q   <= ELEM_GAP_RST;
			char_gap_q   <= CHAR_GAP_RST;
			word_gap_q   <= WORD_GAP_RST;
			group_size_q <= GROUP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DOT:      dot_q        <= cfg_wdata;
				CFG_DASH:     dash_q       <= cfg_wdata;
				CFG_ELEM_GAP: elem_gap_q   <= cfg_wdata;
				CFG_CHAR_GAP: char_gap_q   <= cfg_wdata;
				CFG_WORD_GAP: word_gap_q   <= cfg_wdata;
				CFG_GROUP:    group_size_q <= cfg_wdata[GroupW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos_q <= '0;
		end else if (cmd.close) begin
			group_pos_q <= word_end ? '0 : group_pos_q + 4'd1;
		end
	end

	// character held while its segments go out; elements left-aligned
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_q  <= !entry.hit;
			rem_q  <= entry.count;
			elem_q <= entry.bits << (3'(ElemMax) - entry.count);
		end else if (cmd.advance) begin
			rem_q  <= rem_q - 3'd1;
			elem_q <= {elem_q[ElemMax-2:0], 1'b0};
		end
	end

	assign stat.bad  = bad_q;
	assign stat.more = rem_q > 3'd1;

	always_comb begin
		tone_on        = 1'b0;
		bad_symbol     = 1'b0;
		last           = 1'b0;
		segment_length = '0;
		unique case (kind)
			SEG_TONE: begin
				tone_on        = 1'b1;
				segment_length = elem_q[ElemMax-1] ? dash_q : dot_q;
			end
			SEG_GAP: begin
				segment_length = elem_gap_q;
			end
			SEG_TRAIL: begin
				last           = 1'b1;
				segment_length = word_end ? word_gap_q : char_gap_q;
			end
			SEG_BAD: begin
				bad_symbol     = 1'b1;
				last           = 1'b1;
			end
		endcase
	end

endmodule

// File: sv/mkse_ctrl.sv
module mkse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mkse_pkg::dp_stat_t   stat,
	output mkse_pkg::dp_cmd_t    cmd,
	output mkse_pkg::seg_kind_t  kind
);
	import mkse_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TONE,
		ST_GAP,
		ST_TRAIL,
		ST_BAD
	} state_t;

	state_t state_q;
	logic   in_beat, out_beat;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_TONE || state_q == ST_GAP ||
	                   state_q == ST_TRAIL || state_q == ST_BAD;
	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid && out_ready;

	assign cmd.load    = in_beat;
	assign cmd.advance = state_q == ST_TONE && out_beat && stat.more;
	assign cmd.close   = state_q == ST_TRAIL && out_beat;

	always_comb begin
		unique case (state_q)
			ST_TONE:  kind = SEG_TONE;
			ST_GAP:   kind = SEG_GAP;
			ST_TRAIL: kind = SEG_TRAIL;
			default:  kind = SEG_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_beat) state_q <= ST_CHECK;
				ST_CHECK: state_q <= stat.bad ? ST_BAD : ST_TONE;
				ST_TONE:  if (out_beat) state_q <= stat.more ? ST_GAP : ST_TRAIL;
				ST_GAP:   if (out_beat) state_q <= ST_TONE;
				ST_TRAIL: if (out_beat) state_q <= ST_IDLE;
				ST_BAD:   if (out_beat) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input open while a segment is pending");
	a_load_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> ##1 out_valid) else $error("accepted character produced no segment");
	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> in_ready) else $error("group not closed on return to idle");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.advance, cmd.close})) else $error("overlapping commands");
`endif

endmodule

// File: sv/morse_keying_segment_encoder.sv
// Morse keying segment encoder. Each beat on s_axis carries one ASCII character;
// for it the block sends keying segments on m_axis: a tone segment (dot or dash
// length) per element, a silent element gap between elements, then one trailing
// gap flagged with tlast, a word gap after every group_size-th character and a
// character gap otherwise. An unknown character gives one segment with
// bad_symbol set, length zero and tlast, and leaves the group count alone.
// Per character: accept, a check of the looked-up code, then 2n segments for
// n elements, each held while m_axis_tready is low. The input accepts again
// only once the last segment has been taken. The user writes lengths and group
// size through cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
module morse_keying_segment_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mkse_pkg::CfgIdxW-1:0]   cfg_addr,
	input  logic [mkse_pkg::LenW-1:0]      cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] symbol
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata,   // [23:0] segment_length
	output logic [1:0]                     m_axis_tuser,   // [0] tone_on, [1] bad_symbol
	output logic                           m_axis_tlast    // last
);
	import mkse_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	seg_kind_t kind;

	mkse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd),
		.kind      (kind)
	);

	mkse_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.symbol         (s_axis_tdata),
		.cmd            (cmd),
		.kind           (kind),
		.stat           (stat),
		.tone_on        (m_axis_tuser[0]),
		.segment_length (m_axis_tdata),
		.bad_symbol     (m_axis_tuser[1]),
		.last           (m_axis_tlast)
	);

endmodule

// File: test/morse_keying_segment_encoder_test.sv
`timescale 1ns / 100ps

module morse_keying_segment_encoder_test;
	import mkse_pkg::*;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 16;

	// indexes past the last register, writes there must be ignored
	localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic            tone;
		logic [LenW-1:0] length;
		logic            bad;
		logic            last;
	} keying_seg_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_addr;
	logic [LenW-1:0]    cfg_wdata;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // [7:0] symbol
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [23:0]        m_axis_tdata;   // [23:0] segment_length
	logic [1:0]         m_axis_tuser;   // [0] tone_on, [1] bad_symbol
	logic               m_axis_tlast;

	// shadow of the block's registers and group counter
	logic [LenW-1:0]   dot_len;
	logic [LenW-1:0]   dash_len;
	logic [LenW-1:0]   elem_gap_len;
	logic [LenW-1:0]   char_gap_len;
	logic [LenW-1:0]   word_gap_len;
	logic [GroupW-1:0] chars_per_group;
	logic [GroupW-1:0] group_pos;

	keying_seg_t pending_segments[$];
	logic [7:0]  known_symbols[$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	morse_keying_segment_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic string morse_pattern(input logic [7:0] sym);
		case (sym)
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			"?": return "..--..";
			",": return "--..--";
			"!": return "--...-";
			".": return ".-.-.-";
			";": return "-.-.-.";
			"/": return "-..-.";
			"=": return "-...-";
			"-": return "-....-";
			8'h09: return ".----.";  // tab stands in for the apostrophe
			"(": return "-.--.";
			")": return "-.--.-";
			8'h22: return ".-..-.";
			":": return "---...";
			"_": return "..--.-";
			"@": return ".--.-.";
			default: return "";
		endcase
	endfunction

	// queue the segments one accepted character produces
	function automatic void encode_symbol(input logic [7:0] sym);
		string       pat;
		keying_seg_t seg;
		pat = morse_pattern(sym);
		if (pat.len() == 0) begin
			seg = '{1'b0, '0, 1'b1, 1'b1};
			pending_segments.push_back(seg);
			return;
		end
		for (int i = 0; i < pat.len(); i++) begin
			seg = '{1'b1, (pat[i] == "-") ? dash_len : dot_len, 1'b0, 1'b0};
			pending_segments.push_back(seg);
			if (i + 1 < pat.len()) begin
				seg = '{1'b0, elem_gap_len, 1'b0, 1'b0};
				pending_segments.push_back(seg);
			end
		end
		// at-least comparison: a lowered group size closes the group at once
		if (int'(group_pos) + 1 >= int'(chars_per_group)) begin
			seg = '{1'b0, word_gap_len, 1'b0, 1'b1};
			group_pos = '0;
		end else begin
			seg = '{1'b0, char_gap_len, 1'b0, 1'b1};
			group_pos = group_pos + 1'b1;
		end
		pending_segments.push_back(seg);
	endfunction

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		keying_seg_t got;
		keying_seg_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				encode_symbol(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1], m_axis_tlast};
				if (pending_segments.size() == 0) begin
					errors++;
					$display("%0t: unexpected segment expected none, ", $time,
						"got tone=%0b len=%0d bad=%0b last=%0b",
						got.tone, got.length, got.bad, got.last);
				end else begin
					want = pending_segments.pop_front();
					if (got.tone !== want.tone || got.length !== want.length ||
					    got.bad !== want.bad || got.last !== want.last) begin
						errors++;
						$display("%0t: segment mismatch ", $time,
							"expected tone=%0b len=%0d bad=%0b last=%0b, ",
							want.tone, want.length, want.bad, want.last,
							"got tone=%0b len=%0d bad=%0b last=%0b",
							got.tone, got.length, got.bad, got.last);
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
				$display("morse_keying_segment_encoder_test: FAIL");
				$finish;
			end
		end
	end

	task automatic send_symbol(input logic [7:0] sym);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 8'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = sym;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid, let every expected segment drain, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending_segments.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] value);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		case (idx)
			CFG_DOT:      dot_len = value;
			CFG_DASH:     dash_len = value;
			CFG_ELEM_GAP: elem_gap_len = value;
			CFG_CHAR_GAP: char_gap_len = value;
			CFG_WORD_GAP: word_gap_len = value;
			CFG_GROUP:    chars_per_group = value[GroupW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_all_lengths(input logic [LenW-1:0] value);
		write_reg(CFG_DOT, value);
		write_reg(CFG_DASH, value);
		write_reg(CFG_ELEM_GAP, value);
		write_reg(CFG_CHAR_GAP, value);
		write_reg(CFG_WORD_GAP, value);
	endtask

	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(99) < 85)
			return known_symbols[$urandom_range(known_symbols.size() - 1)];
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [LenW-1:0] pick_length();
		if ($urandom_range(3) == 0)
			return 24'($urandom_range(255));
		return 24'($urandom_range(24'hFFFFFF));
	endfunction

	task automatic test_directed_symbols();
		logic [7:0] syms[$] = '{"E", "T", "0", "5", ",", "!", ".", 8'h09, 8'h22, ":",
			"_", "@", "?", 8'h00, 8'hFF, "a", " ", 8'h80, 8'h7F, "Z"};
		foreach (syms[i])
			send_symbol(syms[i]);
		wait_idle();
	endtask

	task automatic test_group_boundaries();
		write_reg(CFG_GROUP, 24'd1);
		repeat (3) send_symbol(pick_symbol());
		wait_idle();
		// upper bits fall away, leaving a group size of zero
		write_reg(CFG_GROUP, 24'hFFFFF0);
		send_symbol("K");
		send_symbol("q");
		send_symbol("E");
		wait_idle();
		write_reg(CFG_GROUP, 24'd15);
		repeat (16) send_symbol(known_symbols[$urandom_range(known_symbols.size() - 1)]);
		wait_idle();
		write_reg(CFG_GROUP, 24'd5);
		repeat (3) send_symbol(known_symbols[$urandom_range(known_symbols.size() - 1)]);
		wait_idle();
		// shrink the group below the current position
		write_reg(CFG_GROUP, 24'd2);
		send_symbol("M");
		send_symbol("S");
		wait_idle();
	endtask

	task automatic test_length_extremes();
		set_all_lengths('0);
		send_symbol("R");
		send_symbol("0");
		send_symbol(8'hFF);
		wait_idle();
		set_all_lengths('1);
		send_symbol("@");
		send_symbol("T");
		wait_idle();
		write_reg(CFG_SPARE_LO, 24'h000123);
		write_reg(CFG_SPARE_HI, 24'hABCDEF);
		send_symbol("A");
		send_symbol("?");
		wait_idle();
	endtask

	task automatic randomize_registers();
		write_reg(CFG_DOT, pick_length());
		write_reg(CFG_DASH, pick_length());
		write_reg(CFG_ELEM_GAP, pick_length());
		write_reg(CFG_CHAR_GAP, pick_length());
		write_reg(CFG_WORD_GAP, pick_length());
		write_reg(CFG_GROUP, 24'($urandom_range(24'hFFFFFF)));
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		randomize_registers();
		repeat (count) send_symbol(pick_symbol());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		dot_len = DOT_RST;
		dash_len = DASH_RST;
		elem_gap_len = ELEM_GAP_RST;
		char_gap_len = CHAR_GAP_RST;
		word_gap_len = WORD_GAP_RST;
		chars_per_group = GROUP_RST;
		group_pos = '0;
		for (int c = 0; c < 256; c++)
			if (morse_pattern(8'(c)) != "")
				known_symbols.push_back(8'(c));
		send_idle_pct = 34;
		recv_idle_pct = 63;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_symbols();
		test_group_boundaries();
		test_length_extremes();
		test_random_traffic(60, 34, 63);
		test_random_traffic(60, 63, 34);
		test_random_traffic(60, 0, 0);

		repeat (20) @(negedge clk);
		if (errors == 0 && pending_segments.size() == 0) begin
			$display("morse_keying_segment_encoder_test: PASS");
		end else begin
			$display("morse_keying_segment_encoder_test: FAIL");
		end
		$finish;
	end

endmodule
